// ===== src/iuom_pkg.sv =====
`timescale 1ns / 1ps

package iuom_pkg;

    // Q16.16 value width, used for the value fields of the ports.
    localparam int VB = 32;

    localparam int DEF_MAX_INTERVALS = 16;
    localparam int DEF_NUM_VARS      = 4;

    // Action codes.
    localparam logic [1:0] ACT_LOAD      = 2'd0;
    localparam logic [1:0] ACT_TO_OFFSET = 2'd1;
    localparam logic [1:0] ACT_TO_RAW    = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic [1:0]           action;
        logic [1:0]           var_index;
        logic signed [VB-1:0] lower;
        logic signed [VB-1:0] upper;
        logic                 final_interval;
        logic signed [VB-1:0] query_raw;
        logic [VB-1:0]        query_offset;
    } item_t;

    typedef struct packed {
        logic signed [VB-1:0] raw_low;
        logic signed [VB-1:0] raw_high;
        logic [VB-1:0]        offset_value;
        logic [VB-1:0]        total_length;
        logic [1:0]           status;
        logic                 run_end;
    } result_t;

    // Unsigned add that saturates at all ones.
    function automatic logic [VB-1:0] sat_add(input logic [VB-1:0] a, input logic [VB-1:0] b);
        logic [VB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VB] ? {VB{1'b1}} : s[VB-1:0];
    endfunction

endpackage

// ===== src/iuom_ram.sv =====
`timescale 1ns / 1ps

module iuom_ram #(
    parameter int W  = 64,
    parameter int D  = 64,
    parameter int AW = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [D];

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/interval_union_offset_map.sv =====
`timescale 1ns / 1ps

// Interval union and packed offset map for several variables. An item is
// taken when start is high and busy is low; busy then stays high until the
// item is fully done. Results appear one per strobe cycle and cannot be held
// off by the receiver. The two table memories have a registered read, so
// each step is a read followed by a compare: a load keeps busy high while
// it inserts into its sorted pending table, shifting entries up one place
// (at most the pending count) and skipping the last compare when it lands
// at the bottom of the table; a final load then also merges the pending
// entries and delivers the merged intervals, the last strobe falling in the
// first idle cycle; a final load onto a full table skips the insertion, and
// a non-final load onto a full table or any ignored item leaves busy low; a
// query keeps busy high while it walks the union entries and strobes in the
// cycle after, or leaves busy low and strobes in the next cycle when the
// variable has no union.
module interval_union_offset_map #(
    parameter int MAX_INTERVALS = iuom_pkg::DEF_MAX_INTERVALS,
    parameter int NUM_VARS      = iuom_pkg::DEF_NUM_VARS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  iuom_pkg::item_t   item,
    output logic              strobe,
    output iuom_pkg::result_t result
);

    localparam int VB    = iuom_pkg::VB;
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int IW    = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int VW    = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int DEPTH = NUM_VARS * MAX_INTERVALS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_INS_RD  = 10'b0000000010,
        S_INS_CMP = 10'b0000000100,
        S_MRG_RD  = 10'b0000001000,
        S_MRG_CMP = 10'b0000010000,
        S_MRG_END = 10'b0000100000,
        S_EMIT_RD = 10'b0001000000,
        S_EMIT    = 10'b0010000000,
        S_Q_RD    = 10'b0100000000,
        S_Q_CMP   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0]           act_reg, act_next;
    logic [VW-1:0]        var_reg, var_next;
    logic                 fin_reg, fin_next;
    logic signed [VB-1:0] a_reg, a_next, b_reg, b_next, x_reg, x_next;
    logic [VB-1:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]     j_reg, j_next, k_reg, k_next, n_reg, n_next, m_reg, m_next;
    logic signed [VB-1:0] mlo_reg, mlo_next, mhi_reg, mhi_next;
    logic [VB-1:0]        tot_reg, tot_next;
    logic [1:0]           st_reg, st_next;
    iuom_pkg::result_t    res_reg, res_next;
    logic                 strobe_reg, strobe_next;

    // Per-variable counters and flags.
    logic [CNT_W-1:0] pcnt_reg [NUM_VARS];
    logic [CNT_W-1:0] mcnt_reg [NUM_VARS];
    logic [VB-1:0]    ulen_reg [NUM_VARS];
    logic             ovf_reg  [NUM_VARS];

    logic             pcnt_we, mcnt_we, ulen_we, ovf_set, ovf_clr;
    logic [CNT_W-1:0] pcnt_wdata, mcnt_wdata;
    logic [VB-1:0]    ulen_wdata;

    // Memory ports.
    logic                 pw_we, mw_we;
    logic [AW-1:0]        pw_addr, pr_addr, mw_addr, mr_addr;
    logic [2*VB-1:0]      pw_data, pr_data;
    logic [3*VB-1:0]      mw_data, mr_data;
    logic [CNT_W-1:0]     pr_idx, pw_idx;

    logic                 accept, in_valid, less;
    logic [VW-1:0]        vin, vcur;
    logic [AW-1:0]        base;
    logic signed [VB-1:0] pl, ph, ml, mh;
    logic [VB-1:0]        ms, seg_len, run_len, vtotal;

    assign accept   = start && (state_reg == S_IDLE);
    assign in_valid = int'(item.var_index) < NUM_VARS;
    assign vin      = VW'(item.var_index);
    assign vcur     = (state_reg == S_IDLE) ? vin : var_reg;
    assign base     = AW'(int'(var_reg) * MAX_INTERVALS);

    assign pl = pr_data[2*VB-1:VB];
    assign ph = pr_data[VB-1:0];
    assign ml = mr_data[3*VB-1:2*VB];
    assign mh = mr_data[2*VB-1:VB];
    assign ms = mr_data[VB-1:0];

    assign seg_len = mh - ml;
    assign run_len = mhi_reg - mlo_reg;
    assign vtotal  = ulen_reg[var_reg];
    assign less    = (a_reg < pl) || ((a_reg == pl) && (b_reg < ph));

    assign pr_idx  = (state_reg == S_INS_RD) ? (j_reg - CNT_W'(1)) : k_reg;
    assign pr_addr = base + AW'(pr_idx[IW-1:0]);
    assign pw_addr = base + AW'(pw_idx[IW-1:0]);
    assign mr_addr = base + AW'(k_reg[IW-1:0]);
    assign mw_addr = base + AW'(m_reg[IW-1:0]);

    iuom_ram #(.W(2 * VB), .D(DEPTH), .AW(AW)) u_pend (
        .clk  (clk),
        .we   (pw_we),
        .waddr(pw_addr),
        .wdata(pw_data),
        .raddr(pr_addr),
        .rdata(pr_data)
    );

    iuom_ram #(.W(3 * VB), .D(DEPTH), .AW(AW)) u_merged (
        .clk  (clk),
        .we   (mw_we),
        .waddr(mw_addr),
        .wdata(mw_data),
        .raddr(mr_addr),
        .rdata(mr_data)
    );

    // Sequencer: sorted insertion, merge pass, result delivery and walks.
    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        var_next    = var_reg;
        fin_next    = fin_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        x_next      = x_reg;
        rem_next    = rem_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        n_next      = n_reg;
        m_next      = m_reg;
        mlo_next    = mlo_reg;
        mhi_next    = mhi_reg;
        tot_next    = tot_reg;
        st_next     = st_reg;
        res_next    = res_reg;
        strobe_next = 1'b0;

        pcnt_we    = 1'b0;
        pcnt_wdata = pcnt_reg[vcur];
        mcnt_we    = 1'b0;
        mcnt_wdata = m_reg + CNT_W'(1);
        ulen_we    = 1'b0;
        ulen_wdata = iuom_pkg::sat_add(tot_reg, run_len);
        ovf_set    = 1'b0;
        ovf_clr    = 1'b0;

        pw_we   = 1'b0;
        pw_idx  = j_reg;
        pw_data = {a_reg, b_reg};
        mw_we   = 1'b0;
        mw_data = {mlo_reg, mhi_reg, tot_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    var_next = vin;
                    act_next = item.action;
                    fin_next = item.final_interval;
                    a_next   = item.lower;
                    b_next   = (item.upper < item.lower) ? item.lower : item.upper;
                    x_next   = item.query_raw;
                    rem_next = item.query_offset;
                    k_next   = '0;
                    m_next   = '0;
                    tot_next = '0;
                    case (item.action)
                        iuom_pkg::ACT_LOAD:
                        begin
                            if (in_valid)
                            begin
                                if (pcnt_reg[vin] < CNT_W'(MAX_INTERVALS))
                                begin
                                    j_next     = pcnt_reg[vin];
                                    state_next = S_INS_RD;
                                end
                                else
                                begin
                                    ovf_set = 1'b1;
                                    if (item.final_interval)
                                    begin
                                        n_next     = pcnt_reg[vin];
                                        st_next    = iuom_pkg::ST_OVERFLOW;
                                        state_next = S_MRG_RD;
                                    end
                                end
                            end
                        end
                        iuom_pkg::ACT_TO_OFFSET, iuom_pkg::ACT_TO_RAW:
                        begin
                            if (in_valid && (mcnt_reg[vin] != '0))
                            begin
                                n_next     = mcnt_reg[vin];
                                state_next = S_Q_RD;
                            end
                            else
                            begin
                                res_next              = '0;
                                res_next.total_length = in_valid ? ulen_reg[vin] : '0;
                                res_next.status       = iuom_pkg::ST_NOT_FOUND;
                                res_next.run_end      = 1'b1;
                                strobe_next           = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_INS_RD:
            begin
                if (j_reg == '0)
                begin
                    pw_we      = 1'b1;
                    pcnt_we    = 1'b1;
                    pcnt_wdata = pcnt_reg[var_reg] + CNT_W'(1);
                    n_next     = pcnt_reg[var_reg] + CNT_W'(1);
                    st_next    = ovf_reg[var_reg] ? iuom_pkg::ST_OVERFLOW : iuom_pkg::ST_OK;
                    state_next = fin_reg ? S_MRG_RD : S_IDLE;
                end
                else
                begin
                    state_next = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                pw_we = 1'b1;
                if (less)
                begin
                    // Shift the larger entry up one place.
                    pw_data    = pr_data;
                    j_next     = j_reg - CNT_W'(1);
                    state_next = S_INS_RD;
                end
                else
                begin
                    pcnt_we    = 1'b1;
                    pcnt_wdata = pcnt_reg[var_reg] + CNT_W'(1);
                    n_next     = pcnt_reg[var_reg] + CNT_W'(1);
                    st_next    = ovf_reg[var_reg] ? iuom_pkg::ST_OVERFLOW : iuom_pkg::ST_OK;
                    state_next = fin_reg ? S_MRG_RD : S_IDLE;
                end
            end

            S_MRG_RD:
            begin
                state_next = S_MRG_CMP;
            end

            S_MRG_CMP:
            begin
                if (k_reg == '0)
                begin
                    mlo_next = pl;
                    mhi_next = ph;
                end
                else if (pl < mhi_reg)
                begin
                    // Strict overlap extends the running interval.
                    if (mhi_reg < ph)
                    begin
                        mhi_next = ph;
                    end
                end
                else
                begin
                    mw_we    = 1'b1;
                    tot_next = iuom_pkg::sat_add(tot_reg, run_len);
                    m_next   = m_reg + CNT_W'(1);
                    mlo_next = pl;
                    mhi_next = ph;
                end
                k_next     = k_reg + CNT_W'(1);
                state_next = (k_reg + CNT_W'(1) == n_reg) ? S_MRG_END : S_MRG_RD;
            end

            S_MRG_END:
            begin
                // Store the last merged interval and commit the union.
                mw_we      = 1'b1;
                mcnt_we    = 1'b1;
                ulen_we    = 1'b1;
                pcnt_we    = 1'b1;
                pcnt_wdata = '0;
                ovf_clr    = 1'b1;
                tot_next   = ulen_wdata;
                n_next     = m_reg + CNT_W'(1);
                k_next     = '0;
                state_next = S_EMIT_RD;
            end

            S_EMIT_RD:
            begin
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                res_next.raw_low      = ml;
                res_next.raw_high     = mh;
                res_next.offset_value = ms;
                res_next.total_length = tot_reg;
                res_next.status       = st_reg;
                res_next.run_end      = (k_reg + CNT_W'(1) == n_reg);
                strobe_next           = 1'b1;
                k_next                = k_reg + CNT_W'(1);
                state_next            = (k_reg + CNT_W'(1) == n_reg) ? S_IDLE : S_EMIT_RD;
            end

            S_Q_RD:
            begin
                state_next = S_Q_CMP;
            end

            S_Q_CMP:
            begin
                res_next              = '0;
                res_next.total_length = vtotal;
                res_next.run_end      = 1'b1;
                if ((act_reg == iuom_pkg::ACT_TO_OFFSET) && !(x_reg < ml) && !(mh < x_reg))
                begin
                    res_next.offset_value = iuom_pkg::sat_add(ms, x_reg - ml);
                    res_next.status       = iuom_pkg::ST_OK;
                    strobe_next           = 1'b1;
                    state_next            = S_IDLE;
                end
                else if ((act_reg == iuom_pkg::ACT_TO_RAW) && (rem_reg <= seg_len))
                begin
                    res_next.raw_low = ml + rem_reg;
                    res_next.status  = iuom_pkg::ST_OK;
                    strobe_next      = 1'b1;
                    state_next       = S_IDLE;
                end
                else if (k_reg + CNT_W'(1) == n_reg)
                begin
                    res_next.status = iuom_pkg::ST_NOT_FOUND;
                    strobe_next     = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    rem_next   = rem_reg - seg_len;
                    k_next     = k_reg + CNT_W'(1);
                    state_next = S_Q_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    // Per-variable counters and flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < NUM_VARS; v++)
            begin
                pcnt_reg[v] <= '0;
                mcnt_reg[v] <= '0;
                ulen_reg[v] <= '0;
                ovf_reg[v]  <= 1'b0;
            end
        end
        else
        begin
            if (pcnt_we)
            begin
                pcnt_reg[vcur] <= pcnt_wdata;
            end
            if (mcnt_we)
            begin
                mcnt_reg[vcur] <= mcnt_wdata;
            end
            if (ulen_we)
            begin
                ulen_reg[vcur] <= ulen_wdata;
            end
            if (ovf_set)
            begin
                ovf_reg[vcur] <= 1'b1;
            end
            else if (ovf_clr)
            begin
                ovf_reg[vcur] <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        var_reg <= var_next;
        fin_reg <= fin_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        x_reg   <= x_next;
        rem_reg <= rem_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
        n_reg   <= n_next;
        m_reg   <= m_next;
        mlo_reg <= mlo_next;
        mhi_reg <= mhi_next;
        tot_reg <= tot_next;
        st_reg  <= st_next;
        res_reg <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = res_reg;

endmodule
